### rtl/stream_find_replace_assert.svh
// assertion macros for the stream find and replace block
// expects clk and arst_n in the scope where a macro is used
`ifndef STREAM_FIND_REPLACE_ASSERT_SVH
`define STREAM_FIND_REPLACE_ASSERT_SVH
`ifndef SYNTHESIS
`define SFR_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("sfr assertion failed");
`define SFR_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("sfr assertion failed");
`else
`define SFR_ASSERT(lbl, cond)
`define SFR_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### rtl/sfr_pkg.sv
// shared types and constants for the stream find and replace block
// no dependencies
`default_nettype none
package sfr_pkg;
	localparam int MAX_MATCH_DEF   = 8;
	localparam int MAX_REPLACE_DEF = 8;
	localparam int MAX_RES         = 8;
	localparam int LEN_W           = 4;
	localparam int TEXT_W          = 64;
	localparam int CFG_IDX_W       = 2;
	localparam int CNT_W           = $clog2(MAX_MATCH_DEF + 1);

	localparam logic [CFG_IDX_W-1:0] REG_MATCH_LEN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_TEXT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LEN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE_TEXT = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REPL,
		ST_FLUSH,
		ST_END
	} sfr_state_t;

	typedef struct packed {
		logic             append;
		logic             shift;
		logic             clear;
		logic [CNT_W-1:0] app_idx;
		logic [7:0]       app_byte;
	} sfr_win_ctl_t;
endpackage
`default_nettype wire

### rtl/stream_find_replace.sv
// top level: configuration registers, row of window cells, sequencer
// depends on sfr_pkg, sfr_cell and sfr_seq
//
// channel  direction  handshake            payload
// in       sink       in_valid/in_stall    in_byte, in_last
// out      source     out_valid/out_stall  out_byte, has_byte, out_last
// cfg      sink       cfg_wr_en            cfg_index, cfg_data
//
// one item at a time: an accept step, a step per result, a scan decision step,
// a step to close the item and one more to leave a replace or flush step
// the pace is set by the sequencer handing one byte a cycle to the output register
// while the output does not stall; output stalls hold the sequencer
// reset clears window, counts and registers
`default_nettype none
module stream_find_replace import sfr_pkg::*; #(
	parameter int MAX_MATCH   = MAX_MATCH_DEF,
	parameter int MAX_REPLACE = MAX_REPLACE_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           in_byte,
	input  wire logic                 in_last,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [7:0]                out_byte,
	output logic                      has_byte,
	output logic                      out_last,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TEXT_W-1:0]    cfg_data
);
	localparam int CW = $clog2(MAX_MATCH + 1);
	localparam int RW = $clog2(MAX_REPLACE + 1);

	logic [LEN_W-1:0]         match_len_q;
	logic [LEN_W-1:0]         replace_len_q;
	logic [MAX_MATCH*8-1:0]   match_text_q;
	logic [MAX_REPLACE*8-1:0] replace_text_q;

	logic [CW-1:0]  mlen;
	logic [RW-1:0]  rlen;
	sfr_win_ctl_t   win_ctl;
	logic [7:0]     cell_byte [MAX_MATCH];
	logic           cell_occ  [MAX_MATCH];
	logic [MAX_MATCH-1:0] cell_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_len_q    <= '0;
			match_text_q   <= '0;
			replace_len_q  <= '0;
			replace_text_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MATCH_LEN:    match_len_q    <= cfg_data[LEN_W-1:0];
				REG_MATCH_TEXT:   match_text_q   <= cfg_data[MAX_MATCH*8-1:0];
				REG_REPLACE_LEN:  replace_len_q  <= cfg_data[LEN_W-1:0];
				REG_REPLACE_TEXT: replace_text_q <= cfg_data[MAX_REPLACE*8-1:0];
				default: ;
			endcase
		end
	end

	// lengths saturate at the window and replacement sizes
	assign mlen = (match_len_q > LEN_W'(MAX_MATCH)) ? CW'(MAX_MATCH) : CW'(match_len_q);
	assign rlen = (replace_len_q > LEN_W'(MAX_REPLACE)) ? RW'(MAX_REPLACE)
		: RW'(replace_len_q);

	for (genvar i = 0; i < MAX_MATCH; i++) begin : g_cell
		logic [7:0] nb_byte;
		logic       nb_occ;
		if (i == MAX_MATCH - 1) begin : g_tail
			assign nb_byte = '0;
			assign nb_occ  = 1'b0;
		end else begin : g_link
			assign nb_byte = cell_byte[i+1];
			assign nb_occ  = cell_occ[i+1];
		end
		sfr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (win_ctl),
			.app_sel   (win_ctl.app_idx == CNT_W'(i)),
			.nb_byte   (nb_byte),
			.nb_occ    (nb_occ),
			.pat_byte  (match_text_q[i*8 +: 8]),
			.cell_byte (cell_byte[i]),
			.cell_occ  (cell_occ[i]),
			.ok        (cell_ok[i])
		);
	end

	sfr_seq #(
		.MAX_MATCH   (MAX_MATCH),
		.MAX_REPLACE (MAX_REPLACE)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.out_last  (out_last),
		.mlen      (mlen),
		.rlen      (rlen),
		.repl_text (replace_text_q),
		.head_byte (cell_byte[0]),
		.prefix_ok (&cell_ok),
		.win_ctl   (win_ctl)
	);
endmodule
`default_nettype wire

### rtl/sfr_cell.sv
// one window cell: a pending byte, its occupancy and its pattern compare
// depends on sfr_pkg
`default_nettype none
module sfr_cell import sfr_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire sfr_win_ctl_t ctl,
	input  wire logic         app_sel,
	input  wire logic [7:0]   nb_byte,
	input  wire logic         nb_occ,
	input  wire logic [7:0]   pat_byte,
	output logic [7:0]        cell_byte,
	output logic              cell_occ,
	output logic              ok
);
	logic [7:0] byte_q;
	logic       occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.clear) begin
			occ_q <= 1'b0;
		end else if (ctl.shift) begin
			occ_q <= nb_occ;
		end else if (ctl.append && app_sel) begin
			occ_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= nb_byte;
		end else if (ctl.append && app_sel) begin
			byte_q <= ctl.app_byte;
		end
	end

	assign cell_byte = byte_q;
	assign cell_occ  = occ_q;
	assign ok        = !occ_q || (byte_q == pat_byte);
endmodule
`default_nettype wire

### rtl/sfr_seq.sv
// sequencer: scan, replace and flush steps, result hold stage and output register
// depends on sfr_pkg and stream_find_replace_assert.svh
`default_nettype none
`include "stream_find_replace_assert.svh"
module sfr_seq import sfr_pkg::*; #(
	parameter int MAX_MATCH   = MAX_MATCH_DEF,
	parameter int MAX_REPLACE = MAX_REPLACE_DEF,
	localparam int CW = $clog2(MAX_MATCH + 1),
	localparam int RW = $clog2(MAX_REPLACE + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [7:0]               in_byte,
	input  wire logic                     in_last,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [7:0]                    out_byte,
	output logic                          has_byte,
	output logic                          out_last,
	input  wire logic [CW-1:0]            mlen,
	input  wire logic [RW-1:0]            rlen,
	input  wire logic [MAX_REPLACE*8-1:0] repl_text,
	input  wire logic [7:0]               head_byte,
	input  wire logic                     prefix_ok,
	output sfr_win_ctl_t                  win_ctl
);
	localparam int NW = $clog2(MAX_RES + 1);

	sfr_state_t  state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [RW-1:0] rix_q, rix_d;
	logic [NW-1:0] nres_q;
	logic        last_q;
	logic        pend_valid_q;
	logic [7:0]  pend_byte_q;
	logic        pend_has_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_has_q;
	logic        out_last_q;

	logic        out_free, cap, take, end_push;
	logic        prod_req, prod_ok, prod_keep, out_load;
	logic [7:0]  prod_byte, repl_byte;
	logic        prod_has;

	assign out_free  = !out_valid_q || !out_stall;
	assign cap       = (nres_q == NW'(MAX_RES));
	assign prod_ok   = cap || !pend_valid_q || out_free;
	assign prod_keep = prod_req && prod_ok && !cap;
	assign out_load  = (prod_keep && pend_valid_q) || end_push;

	always_comb begin
		repl_byte = '0;
		for (int i = 0; i < MAX_REPLACE; i++) begin
			if (rix_q == RW'(i)) begin
				repl_byte = repl_text[i*8 +: 8];
			end
		end
	end

	always_comb begin
		state_d          = state_q;
		cnt_d            = cnt_q;
		rix_d            = rix_q;
		take             = 1'b0;
		end_push         = 1'b0;
		prod_req         = 1'b0;
		prod_byte        = head_byte;
		prod_has         = 1'b1;
		win_ctl          = '0;
		win_ctl.app_idx  = CNT_W'(cnt_q);
		win_ctl.app_byte = in_byte;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					take           = 1'b1;
					win_ctl.append = 1'b1;
					cnt_d          = cnt_q + CW'(1);
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_q == '0) begin
					state_d = ST_END;
				end else if (cnt_q <= mlen && prefix_ok) begin
					if (cnt_q == mlen) begin
						win_ctl.clear = 1'b1;
						cnt_d         = '0;
						rix_d         = '0;
						state_d       = ST_REPL;
					end else begin
						state_d = last_q ? ST_FLUSH : ST_END;
					end
				end else begin
					prod_req = 1'b1;
					if (prod_ok) begin
						win_ctl.shift = 1'b1;
						cnt_d         = cnt_q - CW'(1);
					end
				end
			end
			ST_REPL: begin
				if (rix_q < rlen) begin
					prod_req  = 1'b1;
					prod_byte = repl_byte;
					if (prod_ok) begin
						rix_d = rix_q + RW'(1);
					end
				end else begin
					state_d = ST_END;
				end
			end
			ST_FLUSH: begin
				if (cnt_q != '0) begin
					prod_req = 1'b1;
					if (prod_ok) begin
						win_ctl.shift = 1'b1;
						cnt_d         = cnt_q - CW'(1);
					end
				end else begin
					state_d = ST_END;
				end
			end
			ST_END: begin
				if (pend_valid_q) begin
					if (out_free) begin
						end_push = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (last_q && nres_q == '0) begin
					// empty end marker
					prod_req  = 1'b1;
					prod_byte = '0;
					prod_has  = 1'b0;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			rix_q        <= '0;
			nres_q       <= '0;
			last_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			rix_q <= rix_d;
			if (take) begin
				nres_q <= '0;
				last_q <= in_last;
			end else if (prod_keep) begin
				nres_q <= nres_q + NW'(1);
			end
			if (prod_keep) begin
				pend_valid_q <= 1'b1;
			end else if (end_push) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (prod_keep) begin
			pend_byte_q <= prod_byte;
			pend_has_q  <= prod_has;
		end
		if (out_load) begin
			out_byte_q <= pend_byte_q;
			out_has_q  <= pend_has_q;
			out_last_q <= end_push && last_q;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign has_byte  = out_has_q;
	assign out_last  = out_last_q;

	`SFR_ASSERT(a_load_into_free_slot, !out_load || out_free)
	`SFR_ASSERT(a_idle_nothing_held, state_q != ST_IDLE || !pend_valid_q)
	`SFR_ASSERT(a_shift_needs_bytes, !win_ctl.shift || cnt_q != '0)
	`SFR_ASSERT_NEXT(a_final_push_ends_item, end_push, state_q == ST_IDLE)
endmodule
`default_nettype wire

### tb/tb_stream_find_replace.sv
// self-checking testbench for stream_find_replace: a directed table, then random text
// with pattern copies, checked against a built-in scan predictor
// depends on sfr_pkg and the stream_find_replace rtl
module tb_stream_find_replace import sfr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] text;
		logic       has;
		logic       lst;
	} text_res_t;

	typedef enum logic {
		ROW_CFG,
		ROW_TEXT
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  b;
		logic        lst;
		logic        typed;
		text_res_t   res;
		logic [3:0]  ml;
		logic [63:0] mt;
		logic [3:0]  rl;
		logic [63:0] rt;
	} dir_row_t;

	localparam text_res_t NO_RES = '0;

	// kind, byte, last, typed, expected, match_len, match_text, replace_len, replace_text
	localparam dir_row_t DIR_ROWS [28] = '{
		'{ROW_TEXT, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_CFG, 8'h00, 1'b0, 1'b0, NO_RES, 4'd2, 64'h6261, 4'd3, 64'h5A5958},
		'{ROW_TEXT, 8'h61, 1'b0, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'h62, 1'b0, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'h61, 1'b0, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'h61, 1'b0, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'h62, 1'b1, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'h61, 1'b1, 1'b1, '{8'h61, 1'b1, 1'b1}, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_CFG, 8'h00, 1'b0, 1'b0, NO_RES, 4'd15, 64'hFFEEDDCCBBAA9988, 4'd0, 64'h0},
		'{ROW_TEXT, 8'h88, 1'b0, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'h99, 1'b0, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'hAA, 1'b0, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'hBB, 1'b0, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'hCC, 1'b0, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'hDD, 1'b0, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'hEE, 1'b0, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_CFG, 8'h00, 1'b0, 1'b0, NO_RES, 4'd1, 64'h0, 4'd15, 64'hFFFFFFFFFFFFFFFF},
		'{ROW_TEXT, 8'h00, 1'b0, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'h01, 1'b1, 1'b1, '{8'h01, 1'b1, 1'b1}, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_CFG, 8'h00, 1'b0, 1'b0, NO_RES, 4'd4, 64'h64636261, 4'd1, 64'h51},
		'{ROW_TEXT, 8'h61, 1'b0, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'h62, 1'b0, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'h63, 1'b0, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_CFG, 8'h00, 1'b0, 1'b0, NO_RES, 4'd2, 64'h6463, 4'd2, 64'h3231},
		'{ROW_TEXT, 8'h64, 1'b0, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0},
		'{ROW_TEXT, 8'h78, 1'b1, 1'b0, NO_RES, 4'd0, 64'h0, 4'd0, 64'h0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           in_byte = '0;
	logic                 in_last = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [7:0]           out_byte;
	logic                 has_byte;
	logic                 out_last;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TEXT_W-1:0]    cfg_data = '0;

	logic [3:0]  pat_len = '0;
	logic [63:0] pat_text = '0;
	logic [3:0]  rep_len = '0;
	logic [63:0] rep_text = '0;
	logic [7:0]  win [0:7];
	int unsigned win_cnt = 0;

	text_res_t pend_text [$];
	int errors = 0;
	int n_in = 0;
	int n_out = 0;
	int n_hits = 0;
	int snd_idle = 0;
	int rcv_idle = 0;

	stream_find_replace i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.out_last  (out_last),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic void emit(ref text_res_t res [$], input logic [7:0] b, input logic h);
		if (res.size() < MAX_RES) begin
			res.push_back(text_res_t'{b, h, 1'b0});
		end
	endfunction

	function automatic void shift_win(ref text_res_t res [$]);
		emit(res, win[0], 1'b1);
		for (int i = 1; i < win_cnt; i++) begin
			win[i-1] = win[i];
		end
		win_cnt--;
	endfunction

	function automatic bit win_is_prefix();
		for (int i = 0; i < win_cnt; i++) begin
			if (win[i] != pat_text[i*8 +: 8]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic void scan_byte(input logic [7:0] b, input logic lst,
			ref text_res_t res [$]);
		int unsigned mlen;
		int unsigned rlen;
		mlen = (pat_len > 8) ? 8 : pat_len;
		rlen = (rep_len > 8) ? 8 : rep_len;
		if (win_cnt == 8) begin
			shift_win(res);
		end
		win[win_cnt] = b;
		win_cnt++;
		while (win_cnt > 0) begin
			if (win_cnt <= mlen && win_is_prefix()) begin
				if (win_cnt == mlen) begin
					for (int i = 0; i < rlen; i++) begin
						emit(res, rep_text[i*8 +: 8], 1'b1);
					end
					win_cnt = 0;
					n_hits++;
				end
				break;
			end
			shift_win(res);
		end
		if (lst) begin
			while (win_cnt > 0) begin
				shift_win(res);
			end
			if (res.size() == 0) begin
				emit(res, 8'h00, 1'b0);
			end
			res[res.size()-1].lst = 1'b1;
		end
	endfunction

	task automatic send_text(input logic [7:0] b, input logic lst, input logic typed,
			input text_res_t typed_res);
		text_res_t res [$];
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= lst;
		do @(posedge clk); while (in_stall);
		scan_byte(b, lst, res);
		if (typed) begin
			pend_text.push_back(typed_res);
		end else begin
			foreach (res[i]) pend_text.push_back(res[i]);
		end
		n_in++;
	endtask

	// hold the sender until all results are out and the block has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (pend_text.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_config(input logic [3:0] ml, input logic [63:0] mt,
			input logic [3:0] rl, input logic [63:0] rt);
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		settle();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_MATCH_LEN;
		cfg_data  <= {noise[63:4], ml};
		@(posedge clk);
		pat_len = ml;
		cfg_index <= REG_MATCH_TEXT;
		cfg_data  <= mt;
		@(posedge clk);
		pat_text = mt;
		cfg_index <= REG_REPLACE_LEN;
		cfg_data  <= {noise[59:0], rl};
		@(posedge clk);
		rep_len = rl;
		cfg_index <= REG_REPLACE_TEXT;
		cfg_data  <= rt;
		@(posedge clk);
		rep_text = rt;
		cfg_wr_en <= 1'b0;
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rcv_idle);
	end

	// output transfer check
	always @(posedge clk) begin
		text_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_out++;
			if (pend_text.size() == 0) begin
				errors++;
				$display("%0t: unexpected result byte %h has %b last %b", $time,
					out_byte, has_byte, out_last);
			end else begin
				want = pend_text.pop_front();
				if (out_byte !== want.text || has_byte !== want.has || out_last !== want.lst) begin
					errors++;
					$display("%0t: expected byte %h has %b last %b, got byte %h has %b last %b",
						$time, want.text, want.has, want.lst, out_byte, has_byte, out_last);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", pend_text.size());
		$display("tb_stream_find_replace: FAIL");
		$finish;
	end

	initial begin
		dir_row_t    row;
		logic [63:0] mt;
		logic [3:0]  ml;
		logic [3:0]  rl;
		logic [7:0]  base;
		int          left;
		int          k;
		int          choice;
		int          elen;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		snd_idle = 20;
		rcv_idle = 78;
		foreach (DIR_ROWS[r]) begin
			row = DIR_ROWS[r];
			if (row.kind == ROW_CFG) begin
				load_config(row.ml, row.mt, row.rl, row.rt);
			end else begin
				send_text(row.b, row.lst, row.typed, row.res);
			end
		end
		for (int mode = 0; mode < 3; mode++) begin
			snd_idle = (mode == 0) ? 20 : (mode == 1) ? 78 : 0;
			rcv_idle = (mode == 0) ? 78 : (mode == 1) ? 20 : 0;
			for (int s = 0; s < 4; s++) begin
				base = 8'($urandom);
				for (int i = 0; i < 8; i++) begin
					mt[i*8 +: 8] = base + 8'($urandom_range(3));
				end
				ml = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 4));
				rl = 4'($urandom_range(15));
				load_config(ml, mt, rl, {$urandom, $urandom});
				elen = (ml > 8) ? 8 : ml;
				left = 11;
				while (left > 0) begin
					choice = $urandom_range(9);
					if (choice < 5 && elen > 0) begin
						k = (choice == 0) ? $urandom_range(1, elen) : elen;
						for (int i = 0; i < k && left > 0; i++) begin
							send_text(mt[i*8 +: 8], $urandom_range(11) == 0, 1'b0, NO_RES);
							left--;
						end
					end else begin
						k = $urandom_range(7);
						send_text((choice < 8) ? mt[k*8 +: 8] : 8'($urandom),
							$urandom_range(11) == 0, 1'b0, NO_RES);
						left--;
					end
				end
			end
		end
		settle();
		$display("input transfers %0d, output transfers %0d, pattern hits %0d", n_in, n_out,
			n_hits);
		$display("covered pass through, saturated lengths, deletion, pattern change mid-text");
		if (errors == 0) begin
			$display("tb_stream_find_replace: PASS");
		end else begin
			$display("tb_stream_find_replace: FAIL");
		end
		$finish;
	end
endmodule
